// ----- design/mafh_pkg.sv -----
package mafh_pkg;

  // register reset and field constants
  localparam logic [15:0] SEARCH_LIMIT_RESET = 16'd8192;
  localparam logic [15:0] POS_MAX            = 16'hFFFF;
  localparam logic [15:0] HDR_FIRST_POS      = 16'd3;
  localparam logic [10:0] SPF_LAYER1         = 11'd384;
  localparam logic [10:0] SPF_LAYER23        = 11'd1152;
  localparam logic [10:0] SYNC_BITS          = 11'h7FF;
  localparam logic [15:0] TOP_REJECT         = 16'hFFFE;

  // version bit codes in the header and reported version codes
  localparam logic [1:0] VBITS_RESERVED = 2'b01;
  localparam logic [1:0] VBITS_MPEG1    = 2'b11;
  localparam logic [1:0] VBITS_MPEG2    = 2'b10;
  localparam logic [1:0] VER_MPEG25     = 2'd0;
  localparam logic [1:0] VER_MPEG1      = 2'd1;
  localparam logic [1:0] VER_MPEG2      = 2'd2;

  localparam logic [1:0] LBITS_RESERVED = 2'b00;
  localparam logic [1:0] LBITS_LAYER1   = 2'b11;
  localparam logic [1:0] LAYER_I        = 2'd1;
  localparam logic [1:0] LAYER_TWO      = 2'd2;
  localparam logic [1:0] FIDX_RESERVED  = 2'b11;
  localparam logic [3:0] BIDX_FREE      = 4'd0;
  localparam logic [3:0] BIDX_BAD       = 4'd15;

  // bitrate tables in kbps, MPEG 1 by layer, then MPEG 2 and 2.5 by layer
  localparam logic [8:0] BR_V1_L1 [16] = '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160,
    9'd192, 9'd224, 9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [8:0] BR_V1_L2 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
    9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [8:0] BR_V1_L3 [16] = '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64,
    9'd80, 9'd96, 9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [8:0] BR_V2_L1 [16] = '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80,
    9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [8:0] BR_V2_L23 [16] = '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40,
    9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

  // sample rates in Hz by frequency index
  localparam logic [15:0] FR_V25 [4] = '{16'd11025, 16'd12000, 16'd8000, 16'd0};
  localparam logic [15:0] FR_V1  [4] = '{16'd44100, 16'd48000, 16'd32000, 16'd0};
  localparam logic [15:0] FR_V2  [4] = '{16'd22050, 16'd24000, 16'd16000, 16'd0};

  typedef struct packed {
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic        header_found;
    logic        search_failed;
    logic [15:0] header_offset;
    logic [1:0]  mpeg_version;
    logic [1:0]  layer_number;
    logic [8:0]  bitrate_kbps;
    logic [15:0] sample_rate_hz;
    logic [10:0] samples_per_frame;
    logic [1:0]  channel_mode;
  } out_t;

  // frame header validity rules
  function automatic logic header_ok(input logic [31:0] w);
    logic ok;
    ok = (w[31:21] == SYNC_BITS)
      && (w[20:19] != VBITS_RESERVED)
      && (w[18:17] != LBITS_RESERVED)
      && (w[15:12] != BIDX_BAD)
      && (w[15:12] != BIDX_FREE)
      && (w[11:10] != FIDX_RESERVED)
      && !(w[19] && (w[18:17] == LBITS_LAYER1) && w[16])
      && (w[31:16] != TOP_REJECT);
    return ok;
  endfunction

  function automatic logic [8:0] bitrate_lookup(input logic [1:0] ver,
                                                input logic [1:0] layer,
                                                input logic [3:0] bidx);
    logic [8:0] r;
    if (ver == VER_MPEG1) begin
      case (layer)
        LAYER_I:   r = BR_V1_L1[bidx];
        LAYER_TWO: r = BR_V1_L2[bidx];
        default:   r = BR_V1_L3[bidx];
      endcase
    end else begin
      r = (layer == LAYER_I) ? BR_V2_L1[bidx] : BR_V2_L23[bidx];
    end
    return r;
  endfunction

  function automatic logic [15:0] freq_lookup(input logic [1:0] ver,
                                              input logic [1:0] fidx);
    logic [15:0] r;
    case (ver)
      VER_MPEG1: r = FR_V1[fidx];
      VER_MPEG2: r = FR_V2[fidx];
      default:   r = FR_V25[fidx];
    endcase
    return r;
  endfunction

endpackage

// ----- design/mafh_stream_if.sv -----
interface mafh_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- design/mpeg_audio_frame_header_finder_unit.sv -----
// an accepted byte's result is registered and held in the output register from the next cycle on
// throughput: one byte per cycle while the result side is ready; the output register is reloaded as it drains
// one result per input byte; the window check and table decode are combinational
// reset: window, byte count and search flag clear, search limit returns to 8192
module mpeg_audio_frame_header_finder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  mafh_stream_if.sink   data_in_i,
  mafh_stream_if.source res_out_o
);
  import mafh_pkg::*;

  logic [23:0] recent_q;
  logic [15:0] pos_q;
  logic        search_over_q;
  logic [15:0] limit_q;
  logic        out_valid_q;
  out_t        out_q;

  logic [31:0] win;
  logic        in_xact;
  logic        hit;
  logic        limit_end;
  logic [1:0]  ver;
  logic [1:0]  layer;
  out_t        res_d;

  // accept whenever the output register is empty or draining
  assign data_in_i.ready = !out_valid_q || res_out_o.ready;
  assign in_xact         = data_in_i.valid && data_in_i.ready;

  assign win = {recent_q, data_in_i.payload.data_byte};

  // header check and field decode
  assign hit = !search_over_q && (pos_q >= HDR_FIRST_POS) && (pos_q < limit_q)
            && header_ok(win);
  assign limit_end = !search_over_q && !hit && ({1'b0, pos_q} + 17'd1 >= {1'b0, limit_q});

  always_comb begin
    case (win[20:19])
      VBITS_MPEG1: ver = VER_MPEG1;
      VBITS_MPEG2: ver = VER_MPEG2;
      default:     ver = VER_MPEG25;
    endcase
    layer = 2'(3'd4 - {1'b0, win[18:17]});
  end

  always_comb begin
    res_d = '0;
    if (hit) begin
      res_d.header_found      = 1'b1;
      res_d.header_offset     = pos_q - HDR_FIRST_POS;
      res_d.mpeg_version      = ver;
      res_d.layer_number      = layer;
      res_d.bitrate_kbps      = bitrate_lookup(ver, layer, win[15:12]);
      res_d.sample_rate_hz    = freq_lookup(ver, win[11:10]);
      res_d.samples_per_frame = (layer == LAYER_I) ? SPF_LAYER1 : SPF_LAYER23;
      res_d.channel_mode      = win[7:6];
    end
    res_d.search_failed = limit_end;
  end

  // search state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q      <= '0;
      pos_q         <= '0;
      search_over_q <= 1'b0;
      limit_q       <= SEARCH_LIMIT_RESET;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (in_xact) begin
        recent_q <= win[23:0];
        if (!search_over_q) begin
          if (hit || limit_end) begin
            search_over_q <= 1'b1;
          end
          if (pos_q != POS_MAX) begin
            pos_q <= pos_q + 16'd1;
          end
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xact) begin
      out_valid_q <= 1'b1;
    end else if (res_out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xact) begin
      out_q <= res_d;
    end
  end

  assign res_out_o.valid   = out_valid_q;
  assign res_out_o.payload = out_q;

  // a result never reports both a header and a failed search
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.header_found && out_q.search_failed))
    else $error("header found and search failed together");

  // the search stays over until reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    search_over_q |=> search_over_q)
    else $error("search flag cleared without reset");

  // after the search every result is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xact && search_over_q) |=> (out_q == '0))
    else $error("result after end of search");

  // byte position advances by one per transaction while searching
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xact && !search_over_q && (pos_q != POS_MAX)) |=> (pos_q == $past(pos_q) + 16'd1))
    else $error("byte position did not advance");

  // a found header always carries a valid layer and nonzero rate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.header_found) |->
      (out_q.layer_number != 2'd0) && (out_q.sample_rate_hz != 16'd0))
    else $error("found header with empty fields");

endmodule

// ----- tb/sv/mafh_header_checker.sv -----
module mafh_header_checker
  import mafh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        byte_valid_i,
  input  logic        byte_ready_i,
  input  in_t         byte_i,
  input  logic        hdr_valid_i,
  input  logic        hdr_ready_i,
  input  out_t        hdr_i,
  output int          errors_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // kbps by row: mpeg 1 layers I..III, then mpeg 2 / 2.5 layers I..III
  localparam logic [8:0] KBPS [6][16] = '{
    '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
    '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0},
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}
  };

  // hz by reported version code, then frequency index
  localparam logic [15:0] HZ [3][4] = '{
    '{11025, 12000, 8000, 0},
    '{44100, 48000, 32000, 0},
    '{22050, 24000, 16000, 0}
  };

  logic [23:0] last3;
  logic [15:0] next_pos;
  logic        scan_done;
  logic [15:0] limit_q;
  out_t        expected_hdr_q [$];
  int          mismatches = 0;

  assign errors_o = mismatches;

  // frame header acceptance rules
  function automatic bit frame_ok(input logic [31:0] w);
    if (w[31:21] != SYNC_BITS) return 1'b0;
    if (w[20:19] == VBITS_RESERVED || w[18:17] == LBITS_RESERVED) return 1'b0;
    if (w[15:12] == BIDX_FREE || w[15:12] == BIDX_BAD) return 1'b0;
    if (w[11:10] == FIDX_RESERVED) return 1'b0;
    // mpeg 1 layer I is refused when bit 16 (protection) is set
    if (w[19] && w[18:17] == LBITS_LAYER1 && w[16]) return 1'b0;
    return w[31:16] != TOP_REJECT;
  endfunction

  // shift one stream byte in and work out the result it should produce
  function automatic out_t scan_byte(input logic [7:0] b);
    logic [31:0] w;
    logic [15:0] pos;
    logic [1:0]  ver;
    logic [1:0]  layer;
    int          row;
    out_t        r;
    w     = {last3, b};
    pos   = next_pos;
    r     = '0;
    last3 = w[23:0];
    if (scan_done) return r;
    if (pos >= 16'd3 && pos < limit_q && frame_ok(w)) begin
      case (w[20:19])
        VBITS_MPEG1: ver = VER_MPEG1;
        VBITS_MPEG2: ver = VER_MPEG2;
        default:     ver = VER_MPEG25;
      endcase
      layer = 2'(3'd4 - {1'b0, w[18:17]});
      row   = ((ver == VER_MPEG1) ? 0 : 3) + int'(layer) - 1;
      r.header_found      = 1'b1;
      r.header_offset     = pos - 16'd3;
      r.mpeg_version      = ver;
      r.layer_number      = layer;
      r.bitrate_kbps      = KBPS[row][w[15:12]];
      r.sample_rate_hz    = HZ[ver][w[11:10]];
      r.samples_per_frame = (layer == LAYER_I) ? 11'd384 : 11'd1152;
      r.channel_mode      = w[7:6];
      scan_done           = 1'b1;
    end else if ({1'b0, pos} + 17'd1 >= {1'b0, limit_q}) begin
      r.search_failed = 1'b1;
      scan_done       = 1'b1;
    end
    if (next_pos != 16'hFFFF) next_pos = next_pos + 16'd1;
    return r;
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t %s: expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  function automatic void compare_result(input out_t want, input out_t got);
    check_field("header_found", want.header_found, got.header_found);
    check_field("search_failed", want.search_failed, got.search_failed);
    check_field("header_offset", want.header_offset, got.header_offset);
    check_field("mpeg_version", want.mpeg_version, got.mpeg_version);
    check_field("layer_number", want.layer_number, got.layer_number);
    check_field("bitrate_kbps", want.bitrate_kbps, got.bitrate_kbps);
    check_field("sample_rate_hz", want.sample_rate_hz, got.sample_rate_hz);
    check_field("samples_per_frame", want.samples_per_frame, got.samples_per_frame);
    check_field("channel_mode", want.channel_mode, got.channel_mode);
  endfunction

  // retire results first, then register writes, then predict new bytes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last3     = '0;
      next_pos  = '0;
      scan_done = 1'b0;
      limit_q   = 16'd8192;
      expected_hdr_q.delete();
      pending_o <= 0;
    end else begin
      if (hdr_valid_i && hdr_ready_i) begin
        if (expected_hdr_q.size() == 0) begin
          $display("%0t result transaction: expected none, actual %h", $time, hdr_i);
          mismatches++;
        end else begin
          compare_result(expected_hdr_q.pop_front(), hdr_i);
        end
      end
      if (cfg_we_i) limit_q = cfg_wdata_i;
      if (byte_valid_i && byte_ready_i) begin
        expected_hdr_q = {expected_hdr_q, scan_byte(byte_i.data_byte)};
      end
      pending_o <= expected_hdr_q.size();
    end
  end

endmodule

// ----- tb/sv/mpeg_audio_frame_header_finder_unit_test.sv -----
module mpeg_audio_frame_header_finder_unit_test;
  import mafh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         STALL_LIMIT  = 1000;
  localparam logic [1:0] VBITS_MPEG25 = 2'b00;

  typedef enum int {
    REJ_SYNC, REJ_VERSION, REJ_LAYER, REJ_FREE_RATE, REJ_BAD_RATE, REJ_FREQ, REJ_L1_CRC,
    REJ_TOP
  } reject_e;

  typedef enum int {END_FOUND, END_WINDOW, END_LOWERED} outcome_e;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [15:0] cfg_wdata  = '0;
  logic        feed_valid = 1'b0;
  in_t         feed_item  = '0;
  logic        sink_ready = 1'b0;
  bit          calm       = 1'b0;
  logic [15:0] tail2      = '0;
  int          sent       = 0;
  int          stuck      = 0;
  int          fails;
  int          pending;

  mafh_stream_if #(.payload_t(in_t))  byte_if ();
  mafh_stream_if #(.payload_t(out_t)) hdr_if ();

  assign byte_if.valid   = feed_valid;
  assign byte_if.payload = feed_item;
  assign hdr_if.ready    = sink_ready;

  mpeg_audio_frame_header_finder_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .data_in_i   (byte_if),
    .res_out_o   (hdr_if)
  );

  mafh_header_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .byte_valid_i (byte_if.valid),
    .byte_ready_i (byte_if.ready),
    .byte_i       (byte_if.payload),
    .hdr_valid_i  (hdr_if.valid),
    .hdr_ready_i  (hdr_if.ready),
    .hdr_i        (hdr_if.payload),
    .errors_o     (fails),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // result side stalls now and then, never during the calm stretch
  always @(posedge clk_i) begin
    sink_ready <= calm || ($urandom_range(99) >= 9);
  end

  // give up after too many cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((byte_if.valid && byte_if.ready) || (hdr_if.valid && hdr_if.ready)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // offer one byte; a guarded byte never lets the next window hold a header
  task automatic push_byte(input logic [7:0] b, input bit guard);
    logic [7:0] v;
    v = b;
    if (guard && tail2[15:5] == SYNC_BITS) v[7:4] = BIDX_BAD;
    while (!calm && $urandom_range(99) < 9) begin
      feed_valid <= 1'b0;
      @(posedge clk_i);
    end
    feed_valid          <= 1'b1;
    feed_item.data_byte <= v;
    @(posedge clk_i);
    while (!byte_if.ready) @(posedge clk_i);
    tail2 = {tail2[7:0], v};
    sent++;
  endtask

  // a leading zero byte keeps the guard off the first two header bytes and
  // closes every window that starts before the frame; then only the third
  // byte decides whether the four-byte window is a header
  task automatic send_frame(input logic [31:0] w);
    push_byte(8'h00, 1'b0);
    push_byte(w[31:24], 1'b1);
    push_byte(w[23:16], 1'b1);
    push_byte(w[15:8], 1'b0);
    push_byte(w[7:0], 1'b1);
  endtask

  // stop feeding until every result is back
  task automatic drain();
    feed_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [15:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] noise();
    return ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
  endfunction

  // random header that passes every rule
  function automatic logic [31:0] valid_frame();
    logic [31:0] w;
    logic [1:0]  vb;
    logic [1:0]  lb;
    w = $urandom;
    case ($urandom_range(2))
      0:       vb = VBITS_MPEG1;
      1:       vb = VBITS_MPEG2;
      default: vb = VBITS_MPEG25;
    endcase
    lb = 2'($urandom_range(1, 3));
    if (vb == VBITS_MPEG1 && lb == LBITS_LAYER1) lb = 2'($urandom_range(1, 2));
    w[31:21] = SYNC_BITS;
    w[20:19] = vb;
    w[18:17] = lb;
    w[15:12] = 4'($urandom_range(1, 14));
    w[11:10] = 2'($urandom_range(2));
    return w;
  endfunction

  // valid header with exactly one rule broken
  function automatic logic [31:0] near_miss();
    logic [31:0] w;
    reject_e     kind;
    int          k;
    w    = valid_frame();
    kind = reject_e'($urandom_range(REJ_TOP));
    k    = 21 + $urandom_range(10);
    case (kind)
      REJ_SYNC:      w[k] = 1'b0;
      REJ_VERSION:   w[20:19] = VBITS_RESERVED;
      REJ_LAYER:     w[18:17] = LBITS_RESERVED;
      REJ_FREE_RATE: w[15:12] = BIDX_FREE;
      REJ_BAD_RATE:  w[15:12] = BIDX_BAD;
      REJ_FREQ:      w[11:10] = FIDX_RESERVED;
      REJ_L1_CRC: begin
        w[20:19] = VBITS_MPEG1;
        w[18:17] = LBITS_LAYER1;
        w[16]    = 1'b1;
      end
      default:       w[31:16] = TOP_REJECT;
    endcase
    return w;
  endfunction

  // mostly near-miss headers, the rest loose bytes
  task automatic random_span(input int upto);
    while (sent < upto) begin
      if ($urandom_range(99) < 65) send_frame(near_miss());
      else push_byte(noise(), 1'b1);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_limit(16'hFFFF);

    // directed rejections, all while the search is open
    push_byte(8'h00, 1'b1);
    send_frame(32'hFFFE_9044);  // mpeg 1 layer I without protection
    send_frame(32'hFFEB_9044);  // reserved version
    send_frame(32'hFFF9_9044);  // reserved layer
    send_frame(32'hFFFB_F044);  // bad bitrate index
    send_frame(32'hFFFB_9C44);  // reserved sample rate
    send_frame(32'hFFFF_9044);  // mpeg 1 layer I with protection

    // random stream under several limits, one stretch with no idling
    random_span(650);
    write_limit(16'($urandom_range(4000, 65534)));
    calm <= 1'b1;
    random_span(1000);
    calm <= 1'b0;
    write_limit(16'($urandom_range(4000, 65534)));
    random_span(1900);

    // close the search one of three ways
    case (outcome_e'($urandom_range(END_LOWERED)))
      END_FOUND: begin
        // sometimes the header ends on the last searched byte
        if ($urandom_range(1)) write_limit(16'(sent + 5));
        send_frame(valid_frame());
      end
      END_WINDOW: begin
        write_limit(16'(sent + $urandom_range(6)));
        repeat (10) push_byte(noise(), 1'b1);
      end
      default: write_limit(16'd4);  // limit below the current position
    endcase

    // after the search everything reads zero, even real headers
    repeat (10) begin
      if ($urandom_range(1)) send_frame(valid_frame());
      else push_byte(noise(), 1'b1);
    end
    write_limit(16'd4);
    repeat (8) push_byte(noise(), 1'b1);
    drain();

    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- mpeg_audio_frame_header_finder_unit.f -----
design/mafh_pkg.sv
design/mafh_stream_if.sv
design/mpeg_audio_frame_header_finder_unit.sv
tb/sv/mafh_header_checker.sv
tb/sv/mpeg_audio_frame_header_finder_unit_test.sv
